@@ sv/nkc_pkg.sv @@
// Shared types and constants of the next-k-combination generator.
`default_nettype none

package nkc_pkg;

	// Fixed field widths
	localparam int N_W      = 8;   // set size register
	localparam int K_W      = 5;   // subset size register and element counter
	localparam int SLOT_W   = 4;   // slot index of a load
	localparam int POS_W    = 4;   // element position of a result
	localparam int CMP_W    = 8;   // common width for position compares
	localparam int CFG_IDX_W = 2;

	// Request codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBSET_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_FILL = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	// Broadcast from the sequencer to every cell
	typedef struct packed {
		logic              start;
		logic              scan;
		logic              fill;
		logic              rotate;
		logic              load_en;
		logic              descending;
		logic [K_W-1:0]    k;
		logic [N_W-1:0]    n;
		logic [SLOT_W-1:0] slot;
	} cell_ctl_t;

	// Status of one cell back to the sequencer
	typedef struct packed {
		logic held;   // scan token sits here
		logic pass;   // token moves on to the left neighbor
		logic found;  // this cell is the pivot
		logic fill;   // refill token sits here
	} cell_stat_t;

endpackage

`default_nettype wire

@@ sv/nkc_req_if.sv @@
// Request channel: load or step transactions.
`default_nettype none

interface nkc_req_if #(
	parameter int VALUE_BITS = 8
);
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [nkc_pkg::SLOT_W-1:0]  slot_index;
	logic [VALUE_BITS-1:0]       load_value;

	modport source (output valid, req_type, slot_index, load_value, input ready);
	modport sink   (input valid, req_type, slot_index, load_value, output ready);
endinterface

`default_nettype wire

@@ sv/nkc_elem_if.sv @@
// Result channel: one element of the combination per transaction.
`default_nettype none

interface nkc_elem_if #(
	parameter int VALUE_BITS = 8
);
	logic                       valid;
	logic                       ready;
	logic [VALUE_BITS-1:0]      element_value;
	logic [nkc_pkg::POS_W-1:0]  element_position;
	logic                       last;
	logic                       exhausted;

	modport source (output valid, element_value, element_position, last, exhausted,
		input ready);
	modport sink   (input valid, element_value, element_position, last, exhausted,
		output ready);
endinterface

`default_nettype wire

@@ sv/nkc_cfg_if.sv @@
// Configuration write channel.
`default_nettype none

interface nkc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [nkc_pkg::CFG_IDX_W-1:0] index;
	logic [nkc_pkg::N_W-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/nkc_cell.sv @@
// One position of the combination: holds its element, scans, refills and rotates.
`default_nettype none

module nkc_cell #(
	parameter int IDX        = 0,
	parameter int VALUE_BITS = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire nkc_pkg::cell_ctl_t     ctl,
	input  wire logic [VALUE_BITS-1:0]  load_value,
	input  wire logic [VALUE_BITS-1:0]  wrap_value,
	input  wire logic [VALUE_BITS-1:0]  left_value,
	input  wire logic                   left_fill,
	input  wire logic [VALUE_BITS-1:0]  right_value,
	input  wire logic                   right_tok,
	output logic [VALUE_BITS-1:0]       value,
	output nkc_pkg::cell_stat_t         stat
);

	localparam int CW = nkc_pkg::CMP_W;
	localparam int BW = ((VALUE_BITS > 9) ? VALUE_BITS : 9) + 2;
	localparam logic [CW-1:0] POS = CW'(IDX);

	logic [VALUE_BITS-1:0] val_q;
	logic                  tok_q;
	logic                  fill_q;
	logic [CW-1:0]         k_ext;
	logic                  active;
	logic                  is_last;
	logic signed [BW-1:0]  v_s;
	logic signed [BW-1:0]  hi;
	logic signed [BW-1:0]  lo;
	logic                  can_move;
	logic [VALUE_BITS-1:0] step_val;
	logic [VALUE_BITS-1:0] fill_val;
	logic                  hit;
	logic                  take_fill;

	assign k_ext   = CW'(ctl.k);
	assign active  = POS < k_ext;
	assign is_last = POS == (k_ext - CW'(1));

	// Bounds in signed arithmetic: in ascending mode a subset larger than the set gives no move
	assign v_s = signed'(BW'(val_q));
	assign hi  = signed'(BW'(ctl.n) - BW'(ctl.k) + BW'(IDX) + BW'(1));
	assign lo  = signed'(BW'(ctl.k) - BW'(IDX));
	assign can_move = ctl.descending ? (v_s > lo) : (v_s < hi);

	assign step_val = ctl.descending ? (val_q - VALUE_BITS'(1)) : (val_q + VALUE_BITS'(1));
	assign fill_val = ctl.descending ? (left_value - VALUE_BITS'(1))
	                                 : (left_value + VALUE_BITS'(1));

	assign hit       = ctl.scan && tok_q && can_move;
	assign take_fill = ctl.fill && left_fill && active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			fill_q <= 1'b0;
		end else begin
			tok_q  <= ctl.start ? (active && is_last) : (ctl.scan && right_tok);
			fill_q <= hit || take_fill;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_en && (CW'(ctl.slot) == POS)) begin
			val_q <= load_value;
		end else if (hit) begin
			val_q <= step_val;
		end else if (take_fill) begin
			val_q <= fill_val;
		end else if (ctl.rotate && active) begin
			val_q <= is_last ? wrap_value : right_value;
		end
	end

	assign value      = val_q;
	assign stat.held  = tok_q;
	assign stat.pass  = tok_q && !can_move;
	assign stat.found = tok_q && can_move;
	assign stat.fill  = fill_q;

endmodule

`default_nettype wire

@@ sv/next_k_combination_generator_unit.sv @@
// Next-k-combination generator: a chain of element cells driven by one sequencer.
//
// Usage: configure set_size (n), subset_size (k) and descending_mode through cfg
// while the block is idle; cfg is always ready and a write is registered when accepted.
// A load transaction on req writes load_value into position slot_index and
// produces nothing. A step transaction moves the stored combination to its
// lexicographic successor (its lexicographic predecessor in descending mode)
// and returns k elements on elem, position 0 first, last set on position k-1,
// exhausted set on all of them when no successor existed (the combination is
// then unchanged). A step runs in three phases over the cell chain: a scan
// token walks left from position k-1 one cell per cycle to the pivot p, a
// refill token walks right from the pivot one cell per cycle and clears once
// it has left position k-1, then the first k cells rotate once per accepted
// element so cell 0 always feeds elem. req is ready only when no step is in
// flight, so the next transaction is accepted in the cycle after the last
// element at the earliest.
// A stall on elem holds the current element and freezes the rotation. Reset
// returns the sequencer to idle and the registers to n=8, k=4, ascending; the
// stored elements are undefined until loaded.
`default_nettype none

module next_k_combination_generator_unit #(
	parameter int MAX_SUBSET = 16,
	parameter int VALUE_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	nkc_req_if.sink   req,
	nkc_elem_if.source elem,
	nkc_cfg_if.sink   cfg
);

	localparam int KW = nkc_pkg::K_W;
	localparam int CW = nkc_pkg::CMP_W;
	localparam int NW = nkc_pkg::N_W;
	localparam int PW = nkc_pkg::POS_W;

	nkc_pkg::state_t    state_q;
	logic [NW-1:0]      set_size_q;
	logic [KW-1:0]      subset_size_q;
	logic               descending_q;
	logic [KW-1:0]      k_eff;
	logic [KW-1:0]      cnt_q;
	logic               ex_q;
	nkc_pkg::cell_ctl_t ctl;
	logic               req_fire;
	logic               out_fire;
	logic               cnt_last;
	logic [VALUE_BITS-1:0]  val_w [MAX_SUBSET];
	nkc_pkg::cell_stat_t    stat_w [MAX_SUBSET];
	logic [MAX_SUBSET-1:0]  held_vec;
	logic [MAX_SUBSET-1:0]  found_vec;
	logic [MAX_SUBSET-1:0]  fill_vec;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q    <= NW'(8);
			subset_size_q <= KW'(4);
			descending_q  <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				nkc_pkg::CFG_SET_SIZE:    set_size_q    <= cfg.data;
				nkc_pkg::CFG_SUBSET_SIZE: subset_size_q <= cfg.data[KW-1:0];
				nkc_pkg::CFG_DESCENDING:  descending_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Saturate k to 1..MAX_SUBSET
	always_comb begin
		if (subset_size_q == '0) begin
			k_eff = KW'(1);
		end else if (CW'(subset_size_q) > CW'(MAX_SUBSET)) begin
			k_eff = KW'(MAX_SUBSET);
		end else begin
			k_eff = subset_size_q;
		end
	end

	assign req_fire = req.valid && req.ready;
	assign out_fire = elem.valid && elem.ready;
	assign cnt_last = cnt_q == (k_eff - KW'(1));

	assign ctl.start      = req_fire && (req.req_type == nkc_pkg::REQ_STEP);
	assign ctl.load_en    = req_fire && (req.req_type == nkc_pkg::REQ_LOAD);
	assign ctl.scan       = state_q == nkc_pkg::ST_SCAN;
	assign ctl.fill       = state_q == nkc_pkg::ST_FILL;
	assign ctl.rotate     = out_fire;
	assign ctl.descending = descending_q;
	assign ctl.k          = k_eff;
	assign ctl.n          = set_size_q;
	assign ctl.slot       = req.slot_index;

	// Cell chain: scan token moves left, refill token and rotation data move along
	for (genvar i = 0; i < MAX_SUBSET; i++) begin : g_cell
		logic [VALUE_BITS-1:0] lval;
		logic [VALUE_BITS-1:0] rval;
		logic                  lfill;
		logic                  rtok;

		if (i == 0) begin : g_left_edge
			assign lval  = '0;
			assign lfill = 1'b0;
		end else begin : g_left
			assign lval  = val_w[i-1];
			assign lfill = stat_w[i-1].fill;
		end

		if (i == MAX_SUBSET - 1) begin : g_right_edge
			assign rval = '0;
			assign rtok = 1'b0;
		end else begin : g_right
			assign rval = val_w[i+1];
			assign rtok = stat_w[i+1].pass;
		end

		nkc_cell #(
			.IDX        (i),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.load_value  (req.load_value),
			.wrap_value  (val_w[0]),
			.left_value  (lval),
			.left_fill   (lfill),
			.right_value (rval),
			.right_tok   (rtok),
			.value       (val_w[i]),
			.stat        (stat_w[i])
		);

		assign held_vec[i]  = stat_w[i].held;
		assign found_vec[i] = stat_w[i].found;
		assign fill_vec[i]  = stat_w[i].fill;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nkc_pkg::ST_IDLE;
			cnt_q   <= '0;
			ex_q    <= 1'b0;
		end else begin
			case (state_q)
				nkc_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (ctl.start) begin
						ex_q    <= 1'b0;
						state_q <= nkc_pkg::ST_SCAN;
					end
				end
				nkc_pkg::ST_SCAN: begin
					if (|found_vec) begin
						state_q <= nkc_pkg::ST_FILL;
					end else if (stat_w[0].pass || !(|held_vec)) begin
						// token fell off position 0: no successor
						ex_q    <= 1'b1;
						state_q <= nkc_pkg::ST_EMIT;
					end
				end
				nkc_pkg::ST_FILL: begin
					if (!(|fill_vec)) begin
						state_q <= nkc_pkg::ST_EMIT;
					end
				end
				nkc_pkg::ST_EMIT: begin
					if (out_fire) begin
						if (cnt_last) begin
							state_q <= nkc_pkg::ST_IDLE;
						end else begin
							cnt_q <= cnt_q + KW'(1);
						end
					end
				end
				default: state_q <= nkc_pkg::ST_IDLE;
			endcase
		end
	end

	assign req.ready             = state_q == nkc_pkg::ST_IDLE;
	assign elem.valid            = state_q == nkc_pkg::ST_EMIT;
	assign elem.element_value    = val_w[0];
	assign elem.element_position = cnt_q[PW-1:0];
	assign elem.last             = cnt_last;
	assign elem.exhausted        = ex_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		elem.valid |-> !req.ready)
		else $error("request accepted while elements are pending");

	a_step_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.req_type == nkc_pkg::REQ_STEP)
		|=> (state_q == nkc_pkg::ST_SCAN && $onehot(held_vec)))
		else $error("step did not place a single scan token");

	a_one_scan_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nkc_pkg::ST_SCAN) |-> $onehot0(held_vec))
		else $error("more than one scan token in the chain");

	a_one_fill_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(fill_vec))
		else $error("more than one refill token in the chain");

	a_last_ends_step: assert property (@(posedge clk) disable iff (!arst_n)
		(elem.valid && elem.ready && elem.last) |=> (state_q == nkc_pkg::ST_IDLE))
		else $error("sequencer did not return to idle after the last element");

endmodule

`default_nettype wire

@@ dv/tb_next_k_combination_generator_unit.sv @@
// Self-checking testbench: steps of the next-k-combination generator against a predicted stream.
`timescale 1ns / 1ps

module tb_next_k_combination_generator_unit;

	localparam int SUBSET_MAX    = 16;
	localparam int VAL_W         = 8;
	localparam int SLOT_BITS     = nkc_pkg::SLOT_W;
	localparam int POS_BITS      = nkc_pkg::POS_W;
	localparam int REG_BITS      = nkc_pkg::N_W;
	localparam int SETTLE_CYCLES = 64;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int PHASE_ITEMS   = 26;
	localparam int NUM_PHASES    = 12;
	localparam int TIMEOUT_NS    = 1500000;

	// Index that decodes to no register
	localparam logic [nkc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic [VAL_W-1:0]          value;
		logic [nkc_pkg::POS_W-1:0] position;
		logic                      last;
		logic                      exhausted;
	} element_t;

	class combo_scoreboard;
		logic [VAL_W-1:0]        combo [SUBSET_MAX];
		logic [nkc_pkg::N_W-1:0] set_n;
		logic [nkc_pkg::K_W-1:0] subset_k;
		logic             descending;
		element_t         expected_elems [$];
		int               errors;
		int               steps;
		int               exhausted_steps;
		int               loads;
		int               checked;

		function new();
			set_n = 8'd8;
			subset_k = 5'd4;
			descending = 1'b0;
			foreach (combo[i]) combo[i] = '0;
			errors = 0;
			steps = 0;
			exhausted_steps = 0;
			loads = 0;
			checked = 0;
		endfunction

		function void note_config(logic [nkc_pkg::CFG_IDX_W-1:0] idx,
			logic [nkc_pkg::N_W-1:0] data);
			case (idx)
				nkc_pkg::CFG_SET_SIZE: set_n = data;
				nkc_pkg::CFG_SUBSET_SIZE: subset_k = data[nkc_pkg::K_W-1:0];
				nkc_pkg::CFG_DESCENDING: descending = data[0];
				default: ;
			endcase
		endfunction

		// Zero acts as one, anything above the array depth saturates
		function int active_k();
			if (subset_k == 0) return 1;
			if (subset_k > SUBSET_MAX) return SUBSET_MAX;
			return int'(subset_k);
		endfunction

		// Move the combination to its successor in place; 0 when none exists
		function bit advance_combo(int kk);
			int p;
			int q;
			int bound;
			for (p = kk - 1; p >= 0; p--) begin
				if (descending) begin
					bound = kk - p;
					if (int'(combo[p]) > bound) begin
						combo[p] = combo[p] - 1'b1;
						for (q = p + 1; q < kk; q++) combo[q] = combo[q-1] - 1'b1;
						return 1'b1;
					end
				end else begin
					// signed bound: may be negative when k exceeds n
					bound = int'(set_n) - kk + p + 1;
					if (int'(combo[p]) < bound) begin
						combo[p] = combo[p] + 1'b1;
						for (q = p + 1; q < kk; q++) combo[q] = combo[q-1] + 1'b1;
						return 1'b1;
					end
				end
			end
			return 1'b0;
		endfunction

		function void note_request(logic kind, logic [nkc_pkg::SLOT_W-1:0] slot,
			logic [VAL_W-1:0] val);
			int kk;
			bit moved;
			element_t e;
			if (kind == nkc_pkg::REQ_LOAD) begin
				combo[slot] = val;
				loads++;
				return;
			end
			kk = active_k();
			moved = advance_combo(kk);
			steps++;
			if (!moved) exhausted_steps++;
			for (int p = 0; p < kk; p++) begin
				e.value = combo[p];
				e.position = POS_BITS'(p);
				e.last = (p == kk - 1);
				e.exhausted = !moved;
				expected_elems.push_back(e);
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) $display("[%0t] check failed: %s", $time, msg);
		endtask

		task check_element(element_t got);
			element_t want;
			if (expected_elems.size() == 0) begin
				report($sformatf("unexpected element value %0d position %0d",
					got.value, got.position));
				return;
			end
			want = expected_elems.pop_front();
			checked++;
			if (got.value !== want.value || got.position !== want.position ||
				got.last !== want.last || got.exhausted !== want.exhausted)
				report($sformatf(
					"got/exp position %0d/%0d value %0d/%0d last %0b/%0b exhausted %0b/%0b",
					got.position, want.position, got.value, want.value,
					got.last, want.last, got.exhausted, want.exhausted));
		endtask

		function int pending();
			return expected_elems.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit steady_flow;
	logic [SUBSET_MAX-1:0] loaded_slots;
	int item_count;
	int settings_used;

	int plan_n [NUM_PHASES] = '{8, 6, 10, 1, 255, 20, 12, 3, 9, 7, 0, 255};
	int plan_k [NUM_PHASES] = '{3, 6, 4, 1, 16, 0, 31, 5, 8'h23, 2, 2, 16};
	bit plan_desc [NUM_PHASES] = '{0, 0, 1, 0, 0, 1, 0, 1, 0, 1, 0, 1};
	bit plan_calm [NUM_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0};

	combo_scoreboard sb = new();

	nkc_req_if #(.VALUE_BITS(VAL_W)) req_ch ();
	nkc_elem_if #(.VALUE_BITS(VAL_W)) elem_ch ();
	nkc_cfg_if cfg_ch ();

	next_k_combination_generator_unit #(
		.MAX_SUBSET(SUBSET_MAX),
		.VALUE_BITS(VAL_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.elem(elem_ch),
		.cfg(cfg_ch)
	);

	always #1 clk = ~clk;

	task automatic push_req(logic kind, logic [nkc_pkg::SLOT_W-1:0] slot,
		logic [VAL_W-1:0] val);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.slot_index <= slot;
		req_ch.load_value <= val;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_request(kind, slot, val);
		if (kind == nkc_pkg::REQ_LOAD) loaded_slots[slot] = 1'b1;
		item_count++;
	endtask

	task automatic load_slot(int slot, int val);
		push_req(nkc_pkg::REQ_LOAD, SLOT_BITS'(slot), VAL_W'(val));
	endtask

	// Slot and value are don't-care on a step; randomize them anyway
	task automatic step_combo();
		push_req(nkc_pkg::REQ_STEP, SLOT_BITS'($urandom_range(0, 15)),
			VAL_W'($urandom_range(0, 255)));
	endtask

	task automatic write_reg(logic [nkc_pkg::CFG_IDX_W-1:0] idx,
		logic [nkc_pkg::N_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		sb.note_config(idx, data);
	endtask

	task automatic configure(int n, int k, bit desc);
		write_reg(nkc_pkg::CFG_SET_SIZE, REG_BITS'(n));
		write_reg(nkc_pkg::CFG_SUBSET_SIZE, REG_BITS'(k));
		write_reg(nkc_pkg::CFG_DESCENDING, REG_BITS'(desc));
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// Drop valid, wait for every expected element, then let the sequencer settle
	task automatic drain();
		int waited;
		waited = 0;
		req_ch.valid <= 1'b0;
		while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic bit slots_ready();
		int kk;
		kk = sb.active_k();
		for (int p = 0; p < kk; p++)
			if (!loaded_slots[p]) return 1'b0;
		return 1'b1;
	endfunction

	// Load a start combination: first, last or random legal one for the current order
	task automatic load_start();
		int kk;
		int lo;
		int hi;
		int prev;
		int v;
		int shape;
		kk = sb.active_k();
		shape = $urandom_range(0, 2);
		prev = sb.descending ? int'(sb.set_n) + 1 : 0;
		for (int p = 0; p < kk; p++) begin
			if (sb.descending) begin
				lo = kk - p;
				hi = prev - 1;
			end else begin
				lo = prev + 1;
				hi = int'(sb.set_n) - kk + p + 1;
			end
			if (hi < lo || lo < 0 || hi > 255)
				v = $urandom_range(0, 255);
			else if (shape == 0)
				v = sb.descending ? hi : lo;
			else if (shape == 1)
				v = sb.descending ? lo : hi;
			else
				v = $urandom_range(lo, hi);
			prev = v;
			load_slot(p, v);
		end
	endtask

	task automatic random_phase(int items);
		int first;
		first = item_count;
		while (item_count - first < items) begin
			if ($urandom_range(0, 9) < 8) begin
				if (!slots_ready() || $urandom_range(0, 3) != 0) load_start();
				repeat ($urandom_range(1, 10)) step_combo();
			end else if ($urandom_range(0, 1) == 0 && slots_ready()) begin
				step_combo();
			end else begin
				load_slot($urandom_range(0, 15), $urandom_range(0, 255));
			end
		end
		drain();
	endtask

	// Result side: random back-pressure per element, check every transaction
	initial begin
		element_t got;
		int stall;
		elem_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				elem_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			elem_ch.ready <= 1'b1;
			do @(posedge clk); while (elem_ch.valid !== 1'b1);
			got.value = elem_ch.element_value;
			got.position = elem_ch.element_position;
			got.last = elem_ch.last;
			got.exhausted = elem_ch.exhausted;
			sb.check_element(got);
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = nkc_pkg::REQ_LOAD;
		req_ch.slot_index = '0;
		req_ch.load_value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = nkc_pkg::CFG_SET_SIZE;
		cfg_ch.data = '0;
		loaded_slots = '0;
		steady_flow = 1'b0;
		item_count = 0;
		settings_used = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings n=8, k=4, ascending: first combination, then the last one
		for (int i = 0; i < 4; i++) load_slot(i, i + 1);
		step_combo();
		for (int i = 0; i < 4; i++) load_slot(i, i + 5);
		step_combo();
		// value above n, then a value out of order
		load_slot(3, 255);
		step_combo();
		load_slot(3, 0);
		step_combo();
		drain();

		// values at the top of the range: no position below its maximum
		configure(255, 4, 1'b0);
		load_slot(0, 252);
		for (int i = 1; i < 4; i++) load_slot(i, 255);
		step_combo();
		drain();

		configure(5, 3, 1'b1);
		for (int i = 0; i < 3; i++) load_slot(i, 5 - i);
		step_combo();
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph == 0) write_reg(CFG_UNUSED, REG_BITS'($urandom_range(0, 255)));
			configure(plan_n[ph], plan_k[ph], plan_desc[ph]);
			steady_flow = plan_calm[ph];
			random_phase(PHASE_ITEMS);
		end

		if (sb.pending() > 0)
			sb.report($sformatf("%0d expected elements never arrived", sb.pending()));
		$display("Run: %0d steps (%0d without successor), %0d loads, %0d elements compared,",
			sb.steps, sb.exhausted_steps, sb.loads, sb.checked);
		$display("over %0d register settings in both orders, with and without stalls.",
			settings_used);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d elements outstanding", sb.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
